### hw/rtl/srbm_pkg.sv
package srbm_pkg;

  // Storage geometry and field widths
  localparam int MAX_FRAMES  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
  localparam int ACC_W       = 24;
  localparam int GAIN_W      = 16;
  localparam int FRAME_W     = 2 * SAMPLE_BITS;
  localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
  localparam int MIX_SHIFT   = SAMPLE_BITS - 2;

  // Stream payload layout
  localparam int IN_DATA_W  = 2 * SAMPLE_BITS + 2 * ACC_W + GAIN_W;
  localparam int OUT_DATA_W = ((2 * ACC_W + CNT_W + 7) / 8) * 8;
  localparam int REQ_W      = 2;
  localparam int FLAG_W     = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic mult;
    logic sum;
    logic load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/stereo_ring_buffer_mix_core.sv
// Stereo overwrite-oldest frame FIFO with gain mix.
// Each beat is captured, then executed (ring update, memory read); a popping read
// also runs multiply and round/saturate steps before the result is loaded.
// One item in flight at once: no new beat is taken until the result is loaded.
// Reset (rst, synchronous): buffer empty, capacity 1024, no result pending, no beat
// taken while rst is high; stored frames are not cleared and no clearing pass is run.
module stereo_ring_buffer_mix_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // left_sample, right_sample, acc_left, acc_right, gain
  input  logic [srbm_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic [srbm_pkg::REQ_W-1:0]      s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // mix_left, mix_right, fill_count, zero pad
  output logic [srbm_pkg::OUT_DATA_W-1:0] m_tdata,
  // consumed, dropped_oldest
  output logic [srbm_pkg::FLAG_W-1:0]     m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srbm_pkg::CNT_W-1:0]      cfg_data
);
  import srbm_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    cfg_we;

  // capacity writes are taken whenever out of reset
  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;

  srbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srbm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .in_last   (s_tlast),
    .cfg_valid (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

### hw/rtl/srbm_ctrl.sv
module srbm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  srbm_pkg::status_t sts,
  output srbm_pkg::cmd_t  cmd
);
  import srbm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_MULT = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no beat is taken while in reset
        in_ready   = !rst;
        cmd.accept = in_valid && !rst;
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.pop ? ST_MULT : ST_DONE;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.load = sts.out_free;
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/srbm_datapath.sv
module srbm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  srbm_pkg::cmd_t                      cmd,
  output srbm_pkg::status_t                   sts,
  input  logic [srbm_pkg::IN_DATA_W-1:0]      in_data,
  input  logic [srbm_pkg::REQ_W-1:0]          in_user,
  input  logic                                in_last,
  input  logic                                cfg_valid,
  input  logic [srbm_pkg::CNT_W-1:0]          cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [srbm_pkg::OUT_DATA_W-1:0]     out_data,
  output logic [srbm_pkg::FLAG_W-1:0]         out_user,
  output logic                                out_last
);
  import srbm_pkg::*;

  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_FRAMES);
  localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(2 ** (MIX_SHIFT - 1));
  localparam logic signed [PROD_W:0] SUM_HI = (PROD_W + 1)'(2 ** (ACC_W - 1) - 1);
  localparam logic signed [PROD_W:0] SUM_LO = -SUM_HI - 1;
  localparam int PAD_W = OUT_DATA_W - 2 * ACC_W - CNT_W;

  // round half up, shift to accumulator scale, add and saturate
  function automatic logic signed [ACC_W-1:0] mix_one(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W:0]   sum;
    rnd = (prod + ROUND_C) >>> MIX_SHIFT;
    sum = {{(PROD_W + 1 - ACC_W){acc[ACC_W-1]}}, acc} + {rnd[PROD_W-1], rnd};
    if (sum > SUM_HI) begin
      mix_one = SUM_HI[ACC_W-1:0];
    end else if (sum < SUM_LO) begin
      mix_one = SUM_LO[ACC_W-1:0];
    end else begin
      mix_one = sum[ACC_W-1:0];
    end
  endfunction

  // captured input beat
  logic [REQ_W-1:0]              req_r;
  logic signed [SAMPLE_BITS-1:0] left_r, right_r;
  logic signed [ACC_W-1:0]       accl_r, accr_r;
  logic [GAIN_W-1:0]             gain_r;
  logic                          last_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r   <= in_user;
      left_r  <= in_data[SAMPLE_BITS-1:0];
      right_r <= in_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
      accl_r  <= in_data[2*SAMPLE_BITS+ACC_W-1:2*SAMPLE_BITS];
      accr_r  <= in_data[2*SAMPLE_BITS+2*ACC_W-1:2*SAMPLE_BITS+ACC_W];
      gain_r  <= in_data[IN_DATA_W-1:2*SAMPLE_BITS+2*ACC_W];
      last_r  <= in_last;
    end
  end

  // ring state
  logic [ADDR_W-1:0] rp;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  cap;

  logic [CNT_W-1:0]  rp_ext, rp_inc_w;
  logic [ADDR_W-1:0] rp_inc;
  logic [CNT_W:0]    wsum, wsum_adj;
  logic [ADDR_W-1:0] wr_idx;
  logic              full, pop, mem_we;
  logic [ADDR_W-1:0] rp_next;
  logic [CNT_W-1:0]  held_next;
  logic              drop_next;
  logic [CNT_W-1:0]  cfg_cap;

  // pointer arithmetic, all modulo capacity
  always_comb begin
    rp_ext   = {{(CNT_W - ADDR_W){1'b0}}, rp};
    rp_inc_w = rp_ext + CNT_W'(1);
    rp_inc   = (rp_inc_w == cap) ? '0 : rp_inc_w[ADDR_W-1:0];
    wsum     = {1'b0, rp_ext} + {1'b0, held};
    wsum_adj = (wsum >= {1'b0, cap}) ? (wsum - {1'b0, cap}) : wsum;
    full     = (held == cap);
    pop      = (req_r == REQ_READ) && (gain_r != '0) && (held != '0);
    // a full buffer overwrites the oldest slot, which is the read pointer
    wr_idx   = full ? rp : wsum_adj[ADDR_W-1:0];
    mem_we   = cmd.exec && (req_r == REQ_WRITE);
  end

  always_comb begin
    rp_next   = rp;
    held_next = held;
    drop_next = 1'b0;
    unique case (req_r)
      REQ_WRITE: begin
        if (full) begin
          rp_next   = rp_inc;
          drop_next = 1'b1;
        end else begin
          held_next = held + CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (pop) begin
          rp_next   = rp_inc;
          held_next = held - CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        rp_next   = '0;
        held_next = '0;
      end
      default: begin
        rp_next   = rp;
      end
    endcase
  end

  // clamp written capacity to 1..MAX_FRAMES
  always_comb begin
    if (cfg_data == '0) begin
      cfg_cap = CNT_W'(1);
    end else if (cfg_data > CAP_MAX) begin
      cfg_cap = CAP_MAX;
    end else begin
      cfg_cap = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp   <= '0;
      held <= '0;
      cap  <= CAP_MAX;
    end else if (cfg_valid) begin
      rp   <= '0;
      held <= '0;
      cap  <= cfg_cap;
    end else if (cmd.exec) begin
      rp   <= rp_next;
      held <= held_next;
    end
  end

  // frame store, one read per item plus one write for a write request
  logic [FRAME_W-1:0] mem [MAX_FRAMES];
  logic [FRAME_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= {right_r, left_r};
    end
    if (cmd.exec) begin
      rd_data <= mem[rp];
    end
  end

  // gain multiply, one product per channel
  logic signed [PROD_W-1:0] prod_l, prod_r;

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod_l <= $signed(rd_data[SAMPLE_BITS-1:0]) * $signed({1'b0, gain_r});
      prod_r <= $signed(rd_data[FRAME_W-1:SAMPLE_BITS]) * $signed({1'b0, gain_r});
    end
  end

  // result staging
  logic signed [ACC_W-1:0] res_l, res_r;
  logic                    res_cons, res_drop;
  logic [CNT_W-1:0]        res_fill;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_cons <= pop;
      res_drop <= drop_next;
      res_fill <= held_next;
      if (req_r == REQ_READ) begin
        res_l <= accl_r;
        res_r <= accr_r;
      end else begin
        res_l <= '0;
        res_r <= '0;
      end
    end else if (cmd.sum) begin
      res_l <= mix_one(accl_r, prod_l);
      res_r <= mix_one(accr_r, prod_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= {{PAD_W{1'b0}}, res_fill, res_r, res_l};
      out_user <= {res_drop, res_cons};
      out_last <= last_r;
    end
  end

  assign sts.pop      = pop;
  assign sts.out_free = !out_valid || out_ready;

endmodule

### hw/rtl/srbm_checker.sv
module srbm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [srbm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [srbm_pkg::FLAG_W-1:0]     m_tuser,
  input logic                            m_tlast
);
  import srbm_pkg::*;

  localparam int FILL_LO = 2 * ACC_W;

  // one item in flight: no new beat straight after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("result changed while stalled");

  // a result never both pops and drops
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("consumed and dropped_oldest both set");

  // fill count stays within the store
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[FILL_LO+CNT_W-1:FILL_LO] <= CNT_W'(MAX_FRAMES))
    else $error("fill count beyond store depth");

endmodule

bind stereo_ring_buffer_mix_core srbm_checker u_srbm_checker (.*);
